[rtl/binary_to_ascii_digits_assert.svh]
// ----------------------------------------------------------------------------
// Binary to ASCII digits: assertion macros
// Clocked on clk_i and disabled while rst_ni is low.
// ----------------------------------------------------------------------------
`ifndef BINARY_TO_ASCII_DIGITS_ASSERT_SVH
`define BINARY_TO_ASCII_DIGITS_ASSERT_SVH

// Property that holds at every clock edge outside reset.
`define B2A_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Condition in one cycle implies a condition in the next cycle.
`define B2A_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

[rtl/b2a_pkg.sv]
// ----------------------------------------------------------------------------
// b2a_pkg
// Shared constants, types and the digit to ASCII mapping of the formatter.
// ----------------------------------------------------------------------------
package b2a_pkg;

  localparam int unsigned VALUE_BITS = 32;
  localparam int unsigned CHAR_W     = 7;
  localparam int unsigned DIG_W      = 4;
  // decimal digits of the largest value
  localparam int unsigned MAX_DIGITS = 10;
  localparam int unsigned IDX_W      = $clog2(MAX_DIGITS);
  localparam int unsigned CNT_W      = $clog2(MAX_DIGITS + 1);

  // v / 10 == (v * DIV10_RECIP) >> DIV10_SHIFT for every 32-bit v
  localparam logic [VALUE_BITS-1:0] DIV10_RECIP = 32'hCCCC_CCCD;
  localparam int unsigned PROD_W      = 2 * VALUE_BITS;
  localparam int unsigned DIV10_SHIFT = 35;
  localparam int unsigned QUOT_W      = PROD_W - DIV10_SHIFT;
  localparam logic [DIG_W-1:0] DEC_RADIX = 4'd10;

  localparam logic [CHAR_W-1:0] ASCII_ZERO = 7'h30;
  localparam logic [CHAR_W-1:0] ASCII_A    = 7'h41;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_HEX,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic load;      // take a new request
    logic mul;       // multiply by the reciprocal of ten
    logic div_step;  // store decimal remainder, keep quotient
    logic hex_step;  // store low nibble, shift right
    logic load_out;  // move next digit to the output register
  } cmd_t;

  typedef struct packed {
    logic in_hex;
    logic dec_zero;
    logic hex_zero;
    logic cnt_last;
    logic out_free;
  } status_t;

  function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIG_W-1:0] d);
    logic [CHAR_W-1:0] d_ext;
    d_ext = {{(CHAR_W-DIG_W){1'b0}}, d};
    if (d < DEC_RADIX) begin
      return ASCII_ZERO + d_ext;
    end
    return ASCII_A + (d_ext - {{(CHAR_W-DIG_W){1'b0}}, DEC_RADIX});
  endfunction

endpackage

[rtl/b2a_if.sv]
// ----------------------------------------------------------------------------
// b2a_in_if / b2a_out_if
// Valid/ready channels for the value request and the character results.
// ----------------------------------------------------------------------------
interface b2a_in_if
  import b2a_pkg::*;
;
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic                  operation;

  modport source (output valid, value, operation, input ready);
  modport sink   (input valid, value, operation, output ready);
endinterface

interface b2a_out_if
  import b2a_pkg::*;
;
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] character;
  logic              last;

  modport source (output valid, character, last, input ready);
  modport sink   (input valid, character, last, output ready);
endinterface

[rtl/b2a_ctrl.sv]
// ----------------------------------------------------------------------------
// b2a_ctrl
// Sequencer: loads a request, steps the digit loop, then drains the digits.
// ----------------------------------------------------------------------------
module b2a_ctrl
  import b2a_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    in_valid_i,
  output logic    in_ready_o,
  input  status_t status_i,
  output cmd_t    cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = status_i.in_hex ? ST_HEX : ST_MUL;
        end
      end
      ST_MUL: state_d = ST_DIV;
      ST_DIV: state_d = status_i.dec_zero ? ST_EMIT : ST_MUL;
      ST_HEX: begin
        if (status_i.hex_zero) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (status_i.out_free && status_i.cnt_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        cmd_o.load = in_valid_i;
      end
      ST_MUL:  cmd_o.mul      = 1'b1;
      ST_DIV:  cmd_o.div_step = 1'b1;
      ST_HEX:  cmd_o.hex_step = 1'b1;
      ST_EMIT: cmd_o.load_out = status_i.out_free;
      default: cmd_o = '0;
    endcase
  end

endmodule

[rtl/b2a_datapath.sv]
// ----------------------------------------------------------------------------
// b2a_datapath
// Working value, reciprocal multiplier, digit buffer and output register.
// ----------------------------------------------------------------------------
`include "binary_to_ascii_digits_assert.svh"

module b2a_datapath
  import b2a_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  cmd_t                  cmd_i,
  output status_t               status_o,
  input  logic [VALUE_BITS-1:0] in_value_i,
  input  logic                  in_operation_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [CHAR_W-1:0]     out_character_o,
  output logic                  out_last_o
);

  logic [VALUE_BITS-1:0] val_q;
  logic [PROD_W-1:0]     prod_q;
  logic [DIG_W-1:0]      dig_q [MAX_DIGITS];
  logic [CNT_W-1:0]      cnt_q;
  logic                  out_valid_q;
  logic [CHAR_W-1:0]     char_q;
  logic                  last_q;

  logic [VALUE_BITS-1:0] quot;
  logic [VALUE_BITS-1:0] quot_x10;
  logic [VALUE_BITS-1:0] rem_full;
  logic [DIG_W-1:0]      rem;
  logic [IDX_W-1:0]      wr_idx;
  logic [CNT_W-1:0]      cnt_dec;
  logic [IDX_W-1:0]      rd_idx;

  assign quot     = {{(VALUE_BITS-QUOT_W){1'b0}}, prod_q[PROD_W-1:DIV10_SHIFT]};
  assign quot_x10 = (quot << 3) + (quot << 1);
  assign rem_full = val_q - quot_x10;
  assign rem      = rem_full[DIG_W-1:0];
  assign wr_idx   = cnt_q[IDX_W-1:0];
  assign cnt_dec  = cnt_q - 1'b1;
  assign rd_idx   = cnt_dec[IDX_W-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= '0;
      end else if (cmd_i.div_step || cmd_i.hex_step) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (cmd_i.load_out) begin
        cnt_q <= cnt_dec;
      end
      if (cmd_i.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q <= in_value_i;
    end else if (cmd_i.div_step) begin
      val_q <= quot;
    end else if (cmd_i.hex_step) begin
      val_q <= val_q >> DIG_W;
    end
    if (cmd_i.mul) begin
      prod_q <= PROD_W'(val_q) * PROD_W'(DIV10_RECIP);
    end
    if (cmd_i.div_step) begin
      dig_q[wr_idx] <= rem;
    end else if (cmd_i.hex_step) begin
      dig_q[wr_idx] <= val_q[DIG_W-1:0];
    end
    if (cmd_i.load_out) begin
      char_q <= digit_to_ascii(dig_q[rd_idx]);
      last_q <= (cnt_q == CNT_W'(1));
    end
  end

  assign status_o.in_hex   = in_operation_i;
  assign status_o.dec_zero = (quot == '0);
  assign status_o.hex_zero = (val_q[VALUE_BITS-1:DIG_W] == '0);
  assign status_o.cnt_last = (cnt_q == CNT_W'(1));
  assign status_o.out_free = !out_valid_q || out_ready_i;

  assign out_valid_o     = out_valid_q;
  assign out_character_o = char_q;
  assign out_last_o      = last_q;

  `B2A_ASSERT(a_cnt_range, cnt_q <= CNT_W'(MAX_DIGITS), "digit count out of range")
  `B2A_ASSERT(a_no_overwrite, !cmd_i.load_out || !out_valid_q || out_ready_i,
              "output register overwritten while stalled")
  `B2A_ASSERT(a_rem_decimal, !cmd_i.div_step || (rem < DEC_RADIX),
              "decimal remainder not below ten")
  `B2A_ASSERT_NEXT(a_last_flag, cmd_i.load_out && (cnt_q == CNT_W'(1)),
                   out_valid_q && last_q, "final digit not marked last")

endmodule

[rtl/binary_to_ascii_digits.sv]
// ----------------------------------------------------------------------------
// binary_to_ascii_digits
// Writes an unsigned value as ASCII decimal or upper-case hex digits.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries value and operation (0 decimal, 1 hexadecimal). A request
//         is taken only while the converter is idle.
//   out_o returns one character per result, most significant digit first,
//         leading zeros dropped; zero gives a single '0'. last marks the
//         least significant digit of each run.
// Sequence (1..10 digits decimal, 1..8 hex):
//   decimal: digit extraction by reciprocal multiply, then remainder,
//            per digit; hex: one nibble per step; then one character per
//            cycle through the output register while out_o is not stalled.
//   A request fills the single digit buffer in the digit loop, then drains
//   it; the two phases do not overlap.
//   A new request is taken once the last character sits in the output
//   register, so its conversion overlaps the wait for that character.
// Reset: returns to idle and empties the output register.
// Stall: with out_o.ready low the output register holds its character and
//   draining of the digit buffer pauses.
// ----------------------------------------------------------------------------
module binary_to_ascii_digits
  import b2a_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  b2a_in_if.sink    in_i,
  b2a_out_if.source out_o
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_i.ready = in_ready;

  b2a_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  b2a_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .status_o        (status),
    .in_value_i      (in_i.value),
    .in_operation_i  (in_i.operation),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .out_character_o (out_o.character),
    .out_last_o      (out_o.last)
  );

endmodule
